/* sv/rrq_pkg.sv */
// Shared types and constants for the round-robin ready queue.
`timescale 1ns / 1ps

package rrq_pkg;

  // Field widths of one request and one result.
  localparam int unsigned ActionW  = 2;
  localparam int unsigned IdW      = 8;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned PosW     = 4;
  localparam int unsigned EntryW   = 5;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  // Requested queue action.
  typedef enum logic [ActionW-1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_ROTATE = 2'd2,
    ACT_FIND   = 2'd3
  } action_e;

  // Result status.
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // What every cell of the row does in one cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD_AT,
    CELL_PUSH,
    CELL_POP_ROT,
    CELL_SPIN
  } cell_mode_e;

  // Control broadcast to the row of cells.
  typedef struct packed {
    cell_mode_e       mode;
    logic [IdW-1:0]   data;
  } cell_ctrl_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    FSM_IDLE   = 4'b0001,
    FSM_EXEC   = 4'b0010,
    FSM_SEARCH = 4'b0100,
    FSM_REPORT = 4'b1000
  } fsm_state_e;

endpackage

/* sv/round_robin_ready_queue_unit.sv */
// Round-robin ready queue: a row of slot cells with the head always in cell 0.
// Append, insert and rotate go from EXEC straight to REPORT; a find passes through
// SEARCH on the way, while the row spins once around.
// A new request is taken only in IDLE, once the last result has been registered at
// the output; a stalled output holds the unit in REPORT.
// Reset empties the queue at once; slot contents are left as they are.
`timescale 1ns / 1ps

module round_robin_ready_queue_unit
  import rrq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [1:0] action, [9:2] thread_id, [15:10] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [1:0] status, [2] found, [6:3] position, [14:7] head_id, [19:15] entry_total,
  // [23:20] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned CountW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IdxW   = $clog2(QUEUE_DEPTH);

  fsm_state_e         state_q, state_d;
  action_e            act_q;
  logic [IdW-1:0]     tid_q;
  logic [CountW-1:0]  count_q, count_d;
  logic [IdxW-1:0]    step_q, step_d;
  status_e            status_q, status_d;
  logic               found_q, found_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic               out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  cell_ctrl_t         ctrl;
  logic [CountW-1:0]  mark;
  logic [IdW-1:0]     slot [QUEUE_DEPTH];
  logic               full;
  logic               in_accept;
  logic               out_free;
  logic [IdW-1:0]     head_id;

  assign full      = (count_q == CountW'(QUEUE_DEPTH));
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign head_id   = (count_q != '0) ? slot[0] : '0;

  assign s_axis_tready = (state_q == FSM_IDLE);

  // Row of slot cells; cell 0 is head; data moves one cell per cycle unless held.
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic [IdW-1:0] prev_data;
    logic [IdW-1:0] next_data;
    if (k == 0) begin : g_first
      assign prev_data = ctrl.data;
    end else begin : g_mid
      assign prev_data = slot[k-1];
    end
    if (k == QUEUE_DEPTH - 1) begin : g_last
      assign next_data = slot[0];
    end else begin : g_inner
      assign next_data = slot[k+1];
    end
    rrq_cell #(
      .IDX   (k),
      .MARKW (CountW)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .mark_i (mark),
      .prev_i (prev_data),
      .next_i (next_data),
      .data_o (slot[k])
    );
  end

  // Sequencer: apply the action to the row, walk it on a find, then report.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    step_d    = step_q;
    status_d  = status_q;
    found_d   = found_q;
    pos_d     = pos_q;
    ctrl.mode = CELL_HOLD;
    ctrl.data = tid_q;
    mark      = count_q;
    case (state_q)
      FSM_IDLE: begin
        if (in_accept) begin
          state_d  = FSM_EXEC;
          status_d = ST_OK;
          found_d  = 1'b0;
          pos_d    = '0;
        end
      end
      FSM_EXEC: begin
        state_d = FSM_REPORT;
        case (act_q)
          ACT_APPEND: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              ctrl.mode = CELL_LOAD_AT;
              count_d   = count_q + CountW'(1);
            end
          end
          ACT_INSERT: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              ctrl.mode = CELL_PUSH;
              count_d   = count_q + CountW'(1);
            end
          end
          ACT_ROTATE: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              ctrl.mode = CELL_POP_ROT;
              ctrl.data = slot[0];
              mark      = count_q - CountW'(1);
            end
          end
          ACT_FIND: begin
            state_d = FSM_SEARCH;
            step_d  = '0;
          end
          default: state_d = FSM_REPORT;
        endcase
      end
      FSM_SEARCH: begin
        // Cell 0 holds the entry at distance step_q from the head.
        ctrl.mode = CELL_SPIN;
        if (!found_q && (CountW'(step_q) < count_q) && (slot[0] == tid_q)) begin
          found_d = 1'b1;
          pos_d   = PosW'(step_q);
        end
        if (step_q == IdxW'(QUEUE_DEPTH - 1)) begin
          state_d = FSM_REPORT;
        end else begin
          step_d = step_q + IdxW'(1);
        end
      end
      FSM_REPORT: begin
        if (out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Request and working registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      act_q <= action_e'(s_axis_tdata[ActionW-1:0]);
      tid_q <= s_axis_tdata[ActionW +: IdW];
    end
    step_q   <= step_d;
    status_q <= status_d;
    found_q  <= found_d;
    pos_q    <= pos_d;
  end

  // Output register: holds a result until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == FSM_REPORT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FSM_REPORT && out_free) begin
      out_data_q <= {4'b0000, EntryW'(count_q), head_id, pos_q, found_q, status_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* sv/rrq_cell.sv */
// One queue slot: holds the identifier at a fixed distance from the head.
`timescale 1ns / 1ps

module rrq_cell
  import rrq_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned MARKW = 5
) (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [MARKW-1:0] mark_i,
  input  logic [IdW-1:0]   prev_i,
  input  logic [IdW-1:0]   next_i,
  output logic [IdW-1:0]   data_o
);

  logic [IdW-1:0] data_q;
  logic [IdW-1:0] data_d;
  logic           at_mark;

  assign at_mark = (mark_i == MARKW'(IDX));

  // Select this slot's next value from itself, a neighbor or the broadcast data.
  always_comb begin
    data_d = data_q;
    case (ctrl_i.mode)
      CELL_HOLD:    data_d = data_q;
      CELL_LOAD_AT: data_d = at_mark ? ctrl_i.data : data_q;
      CELL_PUSH:    data_d = prev_i;
      CELL_POP_ROT: data_d = at_mark ? ctrl_i.data : next_i;
      CELL_SPIN:    data_d = next_i;
      default:      data_d = data_q;
    endcase
  end

  // Slot storage; contents are undefined until written.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* sv/rrq_checker.sv */
// Port-level checks for the round-robin ready queue, bound to the top level.
`timescale 1ns / 1ps

module rrq_checker
  import rrq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic [StatusW-1:0] st;
  logic               fnd;
  logic [PosW-1:0]    pos;
  logic [IdW-1:0]     head;
  logic [EntryW-1:0]  total;

  assign st    = m_axis_tdata[1:0];
  assign fnd   = m_axis_tdata[2];
  assign pos   = m_axis_tdata[6:3];
  assign head  = m_axis_tdata[14:7];
  assign total = m_axis_tdata[19:15];

  // A request is worked on alone: no second request in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while previous one in progress");

  // A stalled result stays offered.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result dropped or changed");

  // A position is only reported with a match.
  a_pos_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !fnd |-> pos == '0)
    else $error("position reported without a match");

  // A rejected rotate leaves an empty queue with a zero head.
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st == ST_EMPTY |-> total == '0 && head == '0 && !fnd)
    else $error("empty status with a non-empty queue");

  // A full rejection comes only with a full queue and never with a match.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st == ST_FULL |-> !fnd && total == EntryW'(QUEUE_DEPTH))
    else $error("full status inconsistent with result");

endmodule

bind round_robin_ready_queue_unit rrq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_rrq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
